>>> rtl/centered_moving_average_unit_defines.svh
// Assertion macros used by the checker file of the moving average unit.
// Depends on nothing; include by bare file name.
`ifndef CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average check failed");

// Check that cons holds in the same cycle as ante.
`define CMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average check failed");

`endif

>>> rtl/cma_pkg.sv
// Shared constants and controller/datapath interface types for the
// centered moving average unit. No dependencies.
`default_nettype none

package cma_pkg;

    localparam int MAX_HALF_DEF    = 15;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HALF_W          = 4;
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(2);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic start_result;
        logic rd_step;
        logic div_start;
        logic div_step;
        logic load_out;
        logic next_age;
    } cma_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emit_ok;
        logic loop_last;
        logic div_done;
        logic out_free;
        logic more;
    } cma_sts_t;

endpackage

`default_nettype wire

>>> rtl/cma_datapath.sv
// Datapath of the centered moving average unit: sample ring, window sum,
// serial divider and output register. Depends on cma_pkg.
`default_nettype none

module cma_datapath #(
    parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [cma_pkg::HALF_W-1:0]    cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    input  wire logic                          out_ready,
    input  wire cma_pkg::cma_cmd_t             cmd,
    output cma_pkg::cma_sts_t                  sts,
    output logic                               out_valid,
    output logic signed [SAMPLE_BITS-1:0]      average,
    output logic                               last_res
);
    import cma_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int AGE_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int HW_W  = $clog2(MAX_HALF + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int DC_W  = $clog2(SUM_W + 1);
    localparam logic [AGE_W-1:0] LAST_SLOT = AGE_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL      = CNT_W'(DEPTH);

    logic [HALF_W-1:0]             half_reg,     half_next;
    logic [AGE_W-1:0]              wp_reg,       wp_next;
    logic [CNT_W-1:0]              filled_reg,   filled_next;
    logic [AGE_W-1:0]              newest_reg,   newest_next;
    logic [HW_W-1:0]               h_reg,        h_next;
    logic                          lastf_reg,    lastf_next;
    logic [AGE_W-1:0]              max_age_reg,  max_age_next;
    logic [AGE_W-1:0]              age_reg,      age_next;
    logic [AGE_W-1:0]              hi_reg,       hi_next;
    logic [AGE_W-1:0]              rd_ptr_reg,   rd_ptr_next;
    logic [AGE_W-1:0]              cnt_reg,      cnt_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic signed [SUM_W-1:0]       sum_reg,      sum_next;
    logic                          neg_reg,      neg_next;
    logic [SUM_W-1:0]              dq_reg,       dq_next;
    logic [CNT_W-1:0]              rem_reg,      rem_next;
    logic [DC_W-1:0]               dcnt_reg,     dcnt_next;
    logic                          ovalid_reg,   ovalid_next;
    logic signed [SAMPLE_BITS-1:0] average_reg,  average_next;
    logic                          last_res_reg, last_res_next;

    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] ring_mem [DEPTH];

    logic [HW_W-1:0]  h_eff;
    logic [CNT_W-1:0] filled_new;
    logic [AGE_W-1:0] max_age_new;
    logic [AGE_W-1:0] age_init;
    logic [AGE_W:0]   age_plus;
    logic [AGE_W-1:0] hi_calc;
    logic [CNT_W-1:0] divisor;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic [SUM_W-1:0] sum_mag;
    logic [SUM_W-1:0] q_fix;

    // Clamp the configured half width to what the ring holds
    always_comb begin
        if (32'(half_reg) > 32'(MAX_HALF)) begin
            h_eff = HW_W'(MAX_HALF);
        end
        else begin
            h_eff = HW_W'(half_reg);
        end
    end

    assign filled_new  = (filled_reg == FULL) ? FULL : filled_reg + CNT_W'(1);
    assign max_age_new = AGE_W'(filled_new - CNT_W'(1));
    assign age_init    = (max_age_new < AGE_W'(h_eff)) ? max_age_new : AGE_W'(h_eff);
    assign age_plus    = {1'b0, age_reg} + (AGE_W + 1)'(h_reg);
    assign hi_calc     = (age_plus > {1'b0, max_age_reg}) ? max_age_reg : age_plus[AGE_W-1:0];
    assign divisor     = CNT_W'(hi_reg) + CNT_W'(1);
    assign trial       = {rem_reg, dq_reg[SUM_W-1]};
    assign diff        = trial - {1'b0, divisor};
    assign sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q_fix       = neg_reg ? (~dq_reg + SUM_W'(1)) : dq_reg;

    always_comb begin
        half_next     = cfg_valid ? cfg_data : half_reg;
        wp_next       = wp_reg;
        filled_next   = filled_reg;
        newest_next   = newest_reg;
        h_next        = h_reg;
        lastf_next    = lastf_reg;
        max_age_next  = max_age_reg;
        age_next      = age_reg;
        hi_next       = hi_reg;
        rd_ptr_next   = rd_ptr_reg;
        cnt_next      = cnt_reg;
        rd_valid_next = cmd.rd_step;
        sum_next      = sum_reg;
        neg_next      = neg_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        ovalid_next   = ovalid_reg;
        average_next  = average_reg;
        last_res_next = last_res_reg;

        if (cmd.accept) begin
            newest_next  = wp_reg;
            h_next       = h_eff;
            lastf_next   = last;
            max_age_next = max_age_new;
            age_next     = age_init;
            if (last) begin
                // clear for the next signal
                wp_next     = '0;
                filled_next = '0;
            end
            else begin
                wp_next     = (wp_reg == LAST_SLOT) ? '0 : wp_reg + AGE_W'(1);
                filled_next = filled_new;
            end
        end

        if (cmd.start_result) begin
            hi_next     = hi_calc;
            rd_ptr_next = newest_reg;
            cnt_next    = '0;
            sum_next    = '0;
        end

        // walk back from the newest sample, one ring slot per cycle
        if (cmd.rd_step) begin
            rd_ptr_next = (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - AGE_W'(1);
            cnt_next    = cnt_reg + AGE_W'(1);
        end

        if (rd_valid_reg) begin
            sum_next = sum_reg + SUM_W'(rd_data_reg);
        end

        if (cmd.div_start) begin
            neg_next  = sum_reg[SUM_W-1];
            dq_next   = sum_mag;
            rem_next  = '0;
            dcnt_next = DC_W'(SUM_W);
        end

        // restoring division, one quotient bit per cycle
        if (cmd.div_step) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[CNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], 1'b1};
            end
            else begin
                rem_next = trial[CNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - DC_W'(1);
        end

        if (cmd.load_out) begin
            ovalid_next   = 1'b1;
            average_next  = q_fix[SAMPLE_BITS-1:0];
            last_res_next = lastf_reg && (age_reg == '0);
        end
        else if (out_ready) begin
            ovalid_next = 1'b0;
        end

        if (cmd.next_age) begin
            age_next = age_reg - AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            half_reg     <= HALF_RESET;
            wp_reg       <= '0;
            filled_reg   <= '0;
            lastf_reg    <= 1'b0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            dcnt_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else begin
            half_reg     <= half_next;
            wp_reg       <= wp_next;
            filled_reg   <= filled_next;
            lastf_reg    <= lastf_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            dcnt_reg     <= dcnt_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk) begin
        newest_reg   <= newest_next;
        h_reg        <= h_next;
        max_age_reg  <= max_age_next;
        age_reg      <= age_next;
        hi_reg       <= hi_next;
        rd_ptr_reg   <= rd_ptr_next;
        sum_reg      <= sum_next;
        neg_reg      <= neg_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        average_reg  <= average_next;
        last_res_reg <= last_res_next;
    end

    // Sample ring: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (cmd.accept) begin
            ring_mem[wp_reg] <= sample;
        end
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    assign sts.emit_ok   = lastf_reg || (max_age_reg >= AGE_W'(h_reg));
    assign sts.loop_last = (cnt_reg == hi_reg);
    assign sts.div_done  = (dcnt_reg == '0);
    assign sts.out_free  = !ovalid_reg || out_ready;
    assign sts.more      = lastf_reg && (age_reg != '0);

    assign out_valid = ovalid_reg;
    assign average   = average_reg;
    assign last_res  = last_res_reg;

endmodule

`default_nettype wire

>>> rtl/cma_controller.sv
// Controller state machine of the centered moving average unit.
// Depends on cma_pkg for the command and status types.
`default_nettype none

module cma_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cma_pkg::cma_sts_t sts,
    output cma_pkg::cma_cmd_t  cmd
);
    import cma_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_TAIL  = 3'd3;
    localparam logic [2:0] ST_DIVS  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_PUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (sts.emit_ok) begin
                    cmd.start_result = 1'b1;
                    state_next       = ST_ACC;
                end
                else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC: begin
                cmd.rd_step = 1'b1;
                if (sts.loop_last) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                // last read data lands in the sum
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_PUT;
                end
                else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (sts.more) begin
                        cmd.next_age = 1'b1;
                        state_next   = ST_SETUP;
                    end
                    else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/centered_moving_average_unit.sv
// Top level of the centered moving average unit.
// Depends on cma_pkg, cma_controller and cma_datapath.
//
// Usage:
//   Samples enter on the input channel (in_valid/in_ready, sample, last); a
//   high last marks the final sample of a signal. Results leave on the
//   output channel (out_valid/out_ready, average, last_res). Each result is
//   the mean of the samples from half_width before to half_width after its
//   position, counting only samples that exist, truncated toward zero.
//   half_width is written through cfg_valid/cfg_data (cfg_ready is always
//   high); write it only while the block is idle.
//   Results lag their sample by half_width positions. A last sample flushes
//   all pending results, the final one flagged by last_res, then the ring
//   starts over for the next signal.
//   One item is processed at a time. An item with no result goes from the
//   setup state straight back to idle. An item with a result reads the ring
//   once per sample averaged, then runs the serial divider at one quotient
//   bit per cycle over the SUM_W-bit sum (SUM_W is 21 at defaults); each
//   further flushed result repeats the setup, ring reads and division.
//   A finished result sits in the output register; the next sample is taken
//   while it waits. A stalled receiver holds the next result back in the
//   datapath. Reset clears the ring position, fill count and output valid
//   and sets half_width to 2.
`default_nettype none

module centered_moving_average_unit #(
    parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cma_pkg::HALF_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      average,
    output logic                               last_res
);
    import cma_pkg::*;

    cma_cmd_t cmd;
    cma_sts_t sts;

    // Configuration takes effect at the next accepted sample
    assign cfg_ready = 1'b1;

    cma_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cma_datapath #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .last      (last),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .average   (average),
        .last_res  (last_res)
    );

endmodule

`default_nettype wire

>>> rtl/cma_checker.sv
// Port-level assertions for the centered moving average unit, bound to the
// top level. Depends on centered_moving_average_unit_defines.svh and cma_pkg.
`default_nettype none
`include "centered_moving_average_unit_defines.svh"

module cma_checker #(
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          last,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] average,
    input wire logic                          last_res
);

    // hold a stalled result transaction
    `CMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(average) && $stable(last_res))

    // one item at a time: busy right after an accepted transaction
    `CMA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a final sample always produces work, so ready stays low through the setup state and the first read step
    `CMA_ASSERT_NEXT(a_flush_busy, clk, rst_n, in_valid && in_ready && last, !in_ready ##1 !in_ready)

    // drop ready only after taking a transaction
    `CMA_ASSERT_SAME(a_ready_drop, clk, rst_n, $fell(in_ready), $past(in_valid))

endmodule

bind centered_moving_average_unit cma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .average   (average),
    .last_res  (last_res)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for centered_moving_average_unit: directed signals, then random ones.
// Depends on cma_pkg and the unit's RTL; keeps its own model of the ring and the window means.

module testbench;

    import cma_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int RING          = 2 * MAX_HALF_DEF + 1;
    localparam int SETTLE_CYCLES = 8;    // lets an item with no result finish
    localparam int TAIL_CYCLES   = 80;   // room for a full window result to finish
    localparam int RANDOM_ITEMS  = 210;

    typedef struct {
        logic signed [SB-1:0] value;
        logic                 fin;
    } sample_item_t;

    typedef struct {
        logic signed [SB-1:0] mean;
        logic                 fin;
    } mean_item_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [HALF_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic signed [SB-1:0] sample    = '0;
    logic                 last      = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [SB-1:0] average;
    logic                 last_res;

    // Stimulus and expectation stores
    sample_item_t pending_samples[$];
    mean_item_t   expected_means[$];

    // Model state: ring of recent samples, write slot, fill count, half width
    logic signed [SB-1:0] ring_model[RING];
    int                   ring_wr   = 0;
    int                   ring_fill = 0;
    logic [HALF_W-1:0]    half_cfg  = HALF_RESET;

    // Idle control: percent chance of a burst after each transaction; 0 means none
    int idle_odds  = 0;
    int in_gap     = 0;
    int out_stall  = 0;

    int mismatches       = 0;
    int means_checked    = 0;
    int samples_accepted = 0;
    int signals_closed   = 0;
    int random_items     = 0;
    bit seen_half[16];

    centered_moving_average_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .average   (average),
        .last_res  (last_res)
    );

    always #1 clk = ~clk;

    // Mean of the window centered 'age' samples back from the newest one,
    // clipped to the samples of this signal that exist.
    function automatic logic signed [SB-1:0] window_mean(input int age, input int h);
        int     lo;
        int     hi;
        int     a;
        int     slot;
        longint acc;
        lo  = (age > h) ? age - h : 0;
        hi  = age + h;
        if (hi > ring_fill - 1)
            hi = ring_fill - 1;
        acc = 0;
        for (a = lo; a <= hi; a++)
        begin
            slot = (ring_wr + RING - ((a + 1) % RING)) % RING;
            acc += ring_model[slot];
        end
        // SystemVerilog division truncates toward zero, as the unit does
        return SB'(acc / longint'(hi - lo + 1));
    endfunction

    // Append one expected mean at the tail of the expectation store.
    function automatic void expect_mean(input logic signed [SB-1:0] m, input logic fin);
        mean_item_t item;
        item.mean = m;
        item.fin  = fin;
        expected_means.insert(expected_means.size(), item);
    endfunction

    // Advance the model by one accepted sample and queue the means it releases.
    function automatic void predict_means(input logic signed [SB-1:0] value, input logic fin);
        int h;
        int a;
        h = (half_cfg > MAX_HALF_DEF) ? MAX_HALF_DEF : int'(half_cfg);
        ring_model[ring_wr] = value;
        ring_wr = (ring_wr + 1) % RING;
        if (ring_fill < RING)
            ring_fill++;
        if (!fin)
        begin
            if (ring_fill > h)
                expect_mean(window_mean(h, h), 1'b0);
        end
        else
        begin
            // Flush every position still waiting for its right-hand samples
            a = (ring_fill - 1 < h) ? ring_fill - 1 : h;
            for (; a >= 0; a--)
                expect_mean(window_mean(a, h), a == 0);
            ring_wr   = 0;
            ring_fill = 0;
        end
    endfunction

    // Driver: record each accepted transaction, then present the next sample
    // or hold off for a burst of idle cycles.
    always @(posedge clk)
    begin
        sample_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_means(sample, last);
                samples_accepted++;
                if (last)
                    signals_closed++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    nxt = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    sample   <= nxt.value;
                    last     <= nxt.fin;
                    if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
                        in_gap = $urandom_range(1, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expected mean,
    // and stall the output in random bursts.
    always @(posedge clk)
    begin
        mean_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $display("%0t: unexpected result, average %0d last_res %0b",
                             $time, average, last_res);
                    mismatches++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    means_checked++;
                    if (average !== want.mean)
                    begin
                        $display("%0t: average expected %0d, actual %0d",
                                 $time, want.mean, average);
                        mismatches++;
                    end
                    if (last_res !== want.fin)
                    begin
                        $display("%0t: last_res expected %0b, actual %0b",
                                 $time, want.fin, last_res);
                        mismatches++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
                    out_stall = $urandom_range(1, 11);
            end
        end
    end

    // Write half_width; call only at a rising edge while the unit is idle.
    task automatic write_half(input logic [HALF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        half_cfg = val;
        seen_half[val] = 1'b1;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued sample is taken and every expected mean has come,
    // then let any result-free item finish inside the unit.
    task automatic drain_unit();
        do @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_means.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SB - 1){1'b1}}};
            1:       return {1'b1, {(SB - 1){1'b0}}};
            2, 3:    return SB'($signed($urandom_range(0, 64)) - 32);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic void queue_one(input logic signed [SB-1:0] value, input logic fin);
        sample_item_t item;
        item.value = value;
        item.fin   = fin;
        pending_samples.insert(pending_samples.size(), item);
    endfunction

    // Queue one signal of random samples; close it with last unless asked not to.
    function automatic void queue_signal(input int len, input bit close);
        int k;
        for (k = 0; k < len; k++)
            queue_one(pick_sample(), close && (k == len - 1));
        random_items += len;
    endfunction

    initial
    begin
        int h;
        int nsig;
        int len;
        int s;
        int halves_used;
        bit close;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        seen_half[HALF_RESET] = 1'b1;

        // Directed, at the reset half width of 2: a one-sample signal, a signal
        // shorter than the window, then a mix of extremes and signs.
        idle_odds = 30;
        queue_one(16'sh7fff, 1'b1);
        queue_one(-16'sh8000, 1'b0);
        queue_one(-16'sh8000, 1'b1);
        queue_one(16'sh7fff, 1'b0);
        queue_one(-16'sh8000, 1'b0);
        queue_one(16'sh0001, 1'b0);
        queue_one(-16'sh0001, 1'b0);
        queue_one(16'sh0007, 1'b1);
        drain_unit();

        // Half width 0: every mean is the sample itself
        write_half(HALF_W'(0));
        queue_one(-16'sh8000, 1'b0);
        queue_one(16'sh7fff, 1'b0);
        queue_one(-16'sh0005, 1'b1);
        drain_unit();

        // Widest window: a short signal flushed at once, then an open signal
        // left idle so the half width changes under it
        write_half(HALF_W'(MAX_HALF_DEF));
        queue_one(16'sh0064, 1'b0);
        queue_one(-16'sh00c8, 1'b0);
        queue_one(16'sh7fff, 1'b1);
        queue_one(-16'sh8000, 1'b0);
        queue_one(16'sh7fff, 1'b0);
        queue_one(-16'sh0003, 1'b0);
        queue_one(16'sh5555, 1'b0);
        queue_one(-16'sh2aab, 1'b0);
        drain_unit();

        // Shrink the window mid-signal; skipped or repeated positions follow
        write_half(HALF_W'(1));
        queue_one(16'sh0011, 1'b0);
        queue_one(-16'sh0022, 1'b0);
        queue_one(16'sh0033, 1'b1);
        drain_unit();

        // Random phases: a new half width each time, a few signals each,
        // sometimes left open so the next phase picks them up mid-signal
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       h = 0;
                1:       h = MAX_HALF_DEF;
                default: h = $urandom_range(0, MAX_HALF_DEF);
            endcase
            write_half(HALF_W'(h));
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 15;
                default: idle_odds = 40;
            endcase
            nsig = $urandom_range(1, 3);
            for (s = 0; s < nsig; s++)
            begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(32, 60);   // wraps the ring
                else
                    len = $urandom_range(1, 2 * h + 4);
                close = !(s == nsig - 1 && $urandom_range(0, 4) == 0);
                queue_signal(len, close);
            end
            drain_unit();
        end

        // Closing stretch at full rate on both sides
        write_half(HALF_W'($urandom_range(0, MAX_HALF_DEF)));
        idle_odds = 0;
        queue_signal($urandom_range(20, 35), 1'b1);
        drain_unit();
        repeat (TAIL_CYCLES) @(posedge clk);

        halves_used = 0;
        for (s = 0; s < 16; s++)
            halves_used += seen_half[s];
        $display("Run covered %0d samples in %0d closed signals, %0d window means checked,",
                 samples_accepted, signals_closed, means_checked);
        $display("using %0d distinct half widths; %0d mismatches.", halves_used, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial
    begin
        #4000000;
        $display("testbench failed");
        $finish;
    end

endmodule
